>>> hdl/multichannel_moving_average_assert.svh
`ifndef MULTICHANNEL_MOVING_AVERAGE_ASSERT_SVH
`define MULTICHANNEL_MOVING_AVERAGE_ASSERT_SVH

// check cons in the cycle after ante, outside reset
`define MMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: word handshake check failed");

// check cons in the cycle after reset is applied
`define MMA_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("%m: reset check failed");

`endif

>>> hdl/mma_pkg.sv
package mma_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int CHANNEL_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [SAMPLE_W-1:0] CLAMP_LIMIT_RESET = 12'hFFF;

  typedef enum logic {
    CFG_CLAMP_LIMIT = 1'b0,
    CFG_UNUSED      = 1'b1
  } cfg_reg_t;

endpackage

>>> hdl/multichannel_moving_average.sv
// Channel   Handshake                   Word
// sample    sample_valid / sample_stall channel, sample
// result    result_valid / result_stall average, channel_error
// config    APB psel / penable          clamp_limit at byte address 0
//
// One word per cycle while sample_stall is low; a taken word's result is
// registered in the s1 stage and then in the result register. The sample ring
// is one memory of CHANNELS*WINDOW entries, read when a word is taken and
// written back when that word leaves the s1 stage. After reset a clearing
// pass zeroes every ring entry; sample_stall stays high for it. A held result
// stalls the sample side only once the middle stage is also full.
module multichannel_moving_average import mma_pkg::*; #(
  parameter int CHANNELS = 8,
  parameter int WINDOW   = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  logic [CHANNEL_W-1:0]  channel,
  input  logic [SAMPLE_W-1:0]   sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [SAMPLE_W-1:0]   average,
  output logic                  channel_error,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W      = $clog2(WINDOW);
  localparam int SUM_W      = SAMPLE_W + POS_W;
  localparam int RING_DEPTH = CHANNELS * WINDOW;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int DIV_SHIFT  = SUM_W + POS_W;
  localparam int DIV_MULT   = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int MULT_W     = SUM_W + 2;
  localparam int PROD_W     = SUM_W + MULT_W;

  logic [SAMPLE_W-1:0] clamp_limit;
  logic                clearing;
  logic [ADDR_W-1:0]   clear_addr;

  logic [POS_W-1:0]    position [CHANNELS];
  logic [SUM_W-1:0]    sum      [CHANNELS];
  logic [SAMPLE_W-1:0] ring     [RING_DEPTH];

  logic                s1_valid;
  logic                s1_error;
  logic [CH_W-1:0]     s1_ch;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [ADDR_W-1:0]   s1_addr;
  logic [SAMPLE_W-1:0] s1_old;

  logic                accept;
  logic                s1_advance;
  logic                channel_ok;
  logic [CH_W-1:0]     ch_idx;
  logic [POS_W-1:0]    cur_pos;
  logic [SAMPLE_W-1:0] clamped;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SUM_W-1:0]    sum_next;
  logic [PROD_W-1:0]   product;
  logic [SAMPLE_W-1:0] quotient;
  logic                cfg_write;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;

  assign accept     = sample_valid && !sample_stall;
  assign s1_advance = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = clearing || (s1_valid && !s1_advance);

  assign channel_ok = {1'b0, channel} < (CHANNEL_W + 1)'(CHANNELS);
  assign ch_idx     = channel[CH_W-1:0];
  assign cur_pos    = position[ch_idx];
  assign clamped    = (sample > clamp_limit) ? clamp_limit : sample;
  assign rd_addr    = ADDR_W'(ch_idx) * ADDR_W'(WINDOW) + ADDR_W'(cur_pos);

  assign sum_next = sum[s1_ch] - SUM_W'(s1_old) + SUM_W'(s1_sample);
  assign product  = PROD_W'(sum_next) * PROD_W'(DIV_MULT);
  assign quotient = product[DIV_SHIFT +: SAMPLE_W];

  always_comb begin
    prdata = '0;
    unique case (cfg_reg_t'(paddr[2]))
      CFG_CLAMP_LIMIT: prdata = APB_DATA_W'(clamp_limit);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_limit <= CLAMP_LIMIT_RESET;
    end else if (cfg_write && cfg_reg_t'(paddr[2]) == CFG_CLAMP_LIMIT) begin
      clamp_limit <= pwdata[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == ADDR_W'(RING_DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        position[i] <= '0;
        sum[i]      <= '0;
      end
    end else begin
      if (accept && channel_ok) begin
        position[ch_idx] <= (cur_pos == POS_W'(WINDOW - 1)) ? '0 : cur_pos + 1'b1;
      end
      if (s1_advance && !s1_error) begin
        sum[s1_ch] <= sum_next;
      end
    end
  end

  // ring memory: clear, write back, read on take
  always_ff @(posedge clk) begin
    if (clearing) begin
      ring[clear_addr] <= '0;
    end else if (s1_advance && !s1_error) begin
      ring[s1_addr] <= s1_sample;
    end
    if (accept && channel_ok) begin
      s1_old <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_error  <= !channel_ok;
      s1_ch     <= ch_idx;
      s1_sample <= channel_ok ? clamped : sample;
      s1_addr   <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      average       <= s1_error ? s1_sample : quotient;
      channel_error <= s1_error;
    end
  end

endmodule

>>> hdl/mma_checker.sv
`include "multichannel_moving_average_assert.svh"

module mma_checker import mma_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                sample_valid,
  input logic                sample_stall,
  input logic                result_valid,
  input logic                result_stall,
  input logic [SAMPLE_W-1:0] average,
  input logic                channel_error
);

  `MMA_ASSERT_AFTER_RESET(a_reset_quiet, sample_stall && !result_valid)
  `MMA_ASSERT_NEXT(a_taken_word_delivered, sample_valid && !sample_stall, ##1 result_valid)
  `MMA_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)
  `MMA_ASSERT_NEXT(a_result_stable, result_valid && result_stall,
    $stable(average) && $stable(channel_error))

endmodule

bind multichannel_moving_average mma_checker u_mma_checker (
  .clk           (clk),
  .rst           (rst),
  .sample_valid  (sample_valid),
  .sample_stall  (sample_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .average       (average),
  .channel_error (channel_error)
);
